// ----- design/framed_message_parser_top_assert.svh -----
// Assertion macros shared by the framed message parser RTL.
`ifndef FRAMED_MESSAGE_PARSER_TOP_ASSERT_SVH
`define FRAMED_MESSAGE_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define FMP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define FMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define FMP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/fmp_pkg.sv -----
// Types and constants shared by the framed message parser modules.
package fmp_pkg;

  localparam int TYPE_MAX_CHARS_DEF    = 6;
  localparam int PAYLOAD_MAX_CHARS_DEF = 15;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // Keywords, first character in the top byte.
  localparam logic [39:0] KW_REF = 40'h48_4C_52_45_46;
  localparam logic [39:0] KW_ENA = 40'h48_4C_45_4E_41;

  localparam int OUT_TDATA_W = 88;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Control from the framing logic to the field decoder.
  typedef struct packed {
    logic clear;  // a new payload starts
    logic take;   // a payload byte is consumed
  } field_ctl_t;

endpackage

// ----- design/fmp_field_dec.sv -----
// Decodes the first two comma-separated payload fields into saturated signed values.
module fmp_field_dec (
  input  logic               clk,
  input  logic               rst_n,
  input  fmp_pkg::field_ctl_t ctl,
  input  logic [7:0]         rx_byte,
  output logic signed [15:0] value_one,
  output logic signed [15:0] value_two
);
  import fmp_pkg::*;

  logic [1:0]         field_num_r, field_num_nxt;
  logic               at_start_r, at_start_nxt;
  logic               neg_r, neg_nxt;
  logic signed [15:0] val1_r, val1_nxt;
  logic signed [15:0] val2_r, val2_nxt;

  logic signed [15:0] acc;
  logic signed [20:0] acc_x10;
  logic signed [8:0]  digit;
  logic signed [8:0]  digit_signed;
  logic signed [20:0] sum;
  logic signed [15:0] sat;
  logic               is_sign;

  // One multiply-by-ten and add, shared by both fields.
  always_comb begin
    acc          = (field_num_r == 2'd0) ? val1_r : val2_r;
    acc_x10      = (21'(acc) <<< 3) + (21'(acc) <<< 1);
    digit        = $signed({1'b0, rx_byte}) - $signed({1'b0, CH_ZERO});
    digit_signed = neg_r ? -digit : digit;
    sum          = acc_x10 + 21'(digit_signed);
    if (sum > 21'sd32767) begin
      sat = 16'sh7FFF;
    end else if (sum < -21'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  always_comb begin
    field_num_nxt = field_num_r;
    at_start_nxt  = at_start_r;
    neg_nxt       = neg_r;
    val1_nxt      = val1_r;
    val2_nxt      = val2_r;
    is_sign       = 1'b0;
    if (ctl.clear) begin
      field_num_nxt = 2'd0;
      at_start_nxt  = 1'b1;
      neg_nxt       = 1'b0;
      val1_nxt      = '0;
      val2_nxt      = '0;
    end else if (ctl.take) begin
      if (rx_byte == CH_COMMA) begin
        if (field_num_r < 2'd2) begin
          field_num_nxt = field_num_r + 2'd1;
        end
        at_start_nxt = 1'b1;
        neg_nxt      = 1'b0;
      end else begin
        if (at_start_r) begin
          at_start_nxt = 1'b0;
          if (rx_byte == CH_MINUS) begin
            neg_nxt = 1'b1;
            is_sign = 1'b1;
          end else if (rx_byte == CH_PLUS) begin
            neg_nxt = 1'b0;
            is_sign = 1'b1;
          end
        end
        if (!is_sign) begin
          if (field_num_r == 2'd0) begin
            val1_nxt = sat;
          end else if (field_num_r == 2'd1) begin
            val2_nxt = sat;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_num_r <= 2'd0;
      at_start_r  <= 1'b1;
      neg_r       <= 1'b0;
      val1_r      <= '0;
      val2_r      <= '0;
    end else begin
      field_num_r <= field_num_nxt;
      at_start_r  <= at_start_nxt;
      neg_r       <= neg_nxt;
      val1_r      <= val1_nxt;
      val2_r      <= val2_nxt;
    end
  end

  assign value_one = val1_r;
  assign value_two = val2_r;

endmodule

// ----- design/framed_message_parser_top.sv -----
// Framed message parser: byte stream in, one decoded result per closed frame out.
//
// in_*  : one received character per transaction in in_tdata[7:0].
// out_* : one result per frame of the form '$' type ',' payload '*'.
// Each accepted byte is handled in the cycle it is accepted; a frame's result
// appears on out_tvalid in the cycle after its closing '*' is accepted.
// Throughput is one byte per cycle unless a result waits on a low out_tready,
// set by the single registered pass that updates the frame state and field decoder.
// The type may hold up to TYPE_MAX_CHARS characters and the payload up to
// PAYLOAD_MAX_CHARS characters; one more drops the frame and the parser hunts
// for the next '$'. The first two payload fields are decoded as signed decimal
// values saturated to 16 bits; later fields only count toward the length.
// Reset (rst_n low, synchronous) puts the parser into the hunt for '$' and
// empties the output register.
// A result waits in the output register while out_tready is low. While it
// waits, in_tready follows out_tready, so no input byte is taken until the
// waiting result is accepted.
`include "framed_message_parser_top_assert.svh"

module framed_message_parser_top #(
  parameter int TYPE_MAX_CHARS    = fmp_pkg::TYPE_MAX_CHARS_DEF,
  parameter int PAYLOAD_MAX_CHARS = fmp_pkg::PAYLOAD_MAX_CHARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [47:0] type_chars, [50:48] type_length, [66:51] first_value,
  // [82:67] second_value, [83] is_reference, [84] is_enable, [87:85] zero
  output logic [fmp_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fmp_pkg::*;

  localparam int SW  = 8 * TYPE_MAX_CHARS;
  localparam int CW  = $clog2(TYPE_MAX_CHARS + 1);
  localparam int SLW = (TYPE_MAX_CHARS > 1) ? $clog2(TYPE_MAX_CHARS) : 1;
  localparam int PCW = $clog2(PAYLOAD_MAX_CHARS + 1);
  localparam bit KW_FITS = (TYPE_MAX_CHARS >= 5);
  localparam int KW_SHIFT = KW_FITS ? 8 * (TYPE_MAX_CHARS - 5) : 0;
  localparam logic [SW-1:0] REF_WORD = KW_FITS ? (SW'(KW_REF) << KW_SHIFT) : '0;
  localparam logic [SW-1:0] ENA_WORD = KW_FITS ? (SW'(KW_ENA) << KW_SHIFT) : '0;

  phase_t           phase_r, phase_nxt;
  logic [CW-1:0]    type_count_r, type_count_nxt;
  logic [SW-1:0]    type_store_r, type_store_nxt;
  logic [PCW-1:0]   payload_count_r, payload_count_nxt;
  logic [SLW-1:0]   slot;

  logic             in_fire;
  logic             result_fire;
  field_ctl_t       fctl;
  logic signed [15:0] value_one;
  logic signed [15:0] value_two;

  logic             out_valid_r;
  logic [47:0]      type_chars_r;
  logic [2:0]       type_length_r;
  logic signed [15:0] first_value_r;
  logic signed [15:0] second_value_r;
  logic             is_ref_r;
  logic             is_ena_r;

  logic [63:0]      type_wide;
  logic [7:0]       count_wide;
  logic             match_ref;
  logic             match_ena;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign slot = SLW'(TYPE_MAX_CHARS - 1) - type_count_r[SLW-1:0];

  always_comb begin
    phase_nxt         = phase_r;
    type_count_nxt    = type_count_r;
    type_store_nxt    = type_store_r;
    payload_count_nxt = payload_count_r;
    fctl              = '0;
    result_fire       = 1'b0;
    if (in_fire) begin
      case (phase_r)
        PH_TYPE: begin
          if (in_tdata == CH_COMMA) begin
            phase_nxt         = PH_PAYLOAD;
            payload_count_nxt = '0;
            fctl.clear        = 1'b1;
          end else if (type_count_r == CW'(TYPE_MAX_CHARS)) begin
            phase_nxt      = PH_HUNT;
            type_count_nxt = '0;
          end else begin
            type_store_nxt[{slot, 3'b000} +: 8] = in_tdata;
            type_count_nxt = type_count_r + CW'(1);
          end
        end
        PH_PAYLOAD: begin
          if (in_tdata == CH_STAR) begin
            phase_nxt   = PH_HUNT;
            result_fire = 1'b1;
          end else if (payload_count_r == PCW'(PAYLOAD_MAX_CHARS)) begin
            phase_nxt         = PH_HUNT;
            payload_count_nxt = '0;
          end else begin
            fctl.take         = 1'b1;
            payload_count_nxt = payload_count_r + PCW'(1);
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (in_tdata == CH_DOLLAR) begin
            phase_nxt      = PH_TYPE;
            type_count_nxt = '0;
            type_store_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HUNT;
      type_count_r    <= '0;
      type_store_r    <= '0;
      payload_count_r <= '0;
    end else begin
      phase_r         <= phase_nxt;
      type_count_r    <= type_count_nxt;
      type_store_r    <= type_store_nxt;
      payload_count_r <= payload_count_nxt;
    end
  end

  fmp_field_dec u_field_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fctl),
    .rx_byte   (in_tdata),
    .value_one (value_one),
    .value_two (value_two)
  );

  always_comb begin
    type_wide  = 64'(type_store_r);
    count_wide = 8'(type_count_r);
    match_ref  = KW_FITS && (type_count_r == CW'(5)) && (type_store_r == REF_WORD);
    match_ena  = KW_FITS && (type_count_r == CW'(5)) && (type_store_r == ENA_WORD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) begin
      type_chars_r   <= type_wide[47:0];
      type_length_r  <= count_wide[2:0];
      first_value_r  <= value_one;
      second_value_r <= value_two;
      is_ref_r       <= match_ref;
      is_ena_r       <= match_ena;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, is_ena_r, is_ref_r, second_value_r, first_value_r,
                       type_length_r, type_chars_r};

  `FMP_ASSERT_NEXT(a_result_follows_star, clk, rst_n,
    in_fire && (phase_r == PH_PAYLOAD) && (in_tdata == CH_STAR), out_tvalid)
  `FMP_ASSERT_NOW(a_type_count_bound, clk, rst_n, 1'b1,
    type_count_r <= CW'(TYPE_MAX_CHARS))
  `FMP_ASSERT_NOW(a_payload_count_bound, clk, rst_n, 1'b1,
    payload_count_r <= PCW'(PAYLOAD_MAX_CHARS))
  `FMP_ASSERT_NOW(a_flags_exclusive, clk, rst_n, out_tvalid,
    !(is_ref_r && is_ena_r) && (!(is_ref_r || is_ena_r) || (type_length_r == 3'd5)))

endmodule

// ----- dv/tb_framed_message_parser_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the framed message parser: random byte streams, predicted results.
module tb_framed_message_parser_top;
  import fmp_pkg::*;

  typedef logic [7:0] octet_t;

  typedef struct {
    logic [47:0]        type_chars;
    logic [2:0]         type_length;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
    logic               is_reference;
    logic               is_enable;
  } frame_result_t;

  localparam int     TYPE_MAX     = TYPE_MAX_CHARS_DEF;
  localparam int     PAYLOAD_MAX  = PAYLOAD_MAX_CHARS_DEF;
  localparam int     RANDOM_BYTES = 1550;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_CYCLES = 4;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam octet_t CH_UPPER_A   = 8'h41;

  // Tracks the parser's frame state and keeps the decoded frames still owed by the block.
  class frame_scoreboard;
    phase_t        phase;
    int            type_count;
    logic [47:0]   type_store;
    int            payload_count;
    int            field_number;
    bit            at_field_start;
    bit            field_negative;
    int            value_one;
    int            value_two;
    frame_result_t owed_frames[$];
    int            errors;
    int            frames_checked;
    int            keyword_frames;
    int            saturated_frames;

    function new();
      phase          = PH_HUNT;
      type_count     = 0;
      type_store     = '0;
      payload_count  = 0;
      field_number   = 0;
      at_field_start = 1'b1;
      field_negative = 1'b0;
      value_one      = 0;
      value_two      = 0;
      errors         = 0;
      frames_checked = 0;
      keyword_frames = 0;
      saturated_frames = 0;
    endfunction

    static function int add_digit(int acc, octet_t c, bit neg);
      int d;
      int v;
      d = int'(c) - int'(CH_ZERO);
      v = acc * 10 + (neg ? -d : d);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
    endfunction

    function void decode_payload_byte(octet_t c);
      if (c == CH_COMMA) begin
        if (field_number < 2) field_number++;
        at_field_start = 1'b1;
        field_negative = 1'b0;
        return;
      end
      if (at_field_start) begin
        at_field_start = 1'b0;
        if (c == CH_MINUS) begin
          field_negative = 1'b1;
          return;
        end
        if (c == CH_PLUS) begin
          field_negative = 1'b0;
          return;
        end
      end
      if (field_number == 0) value_one = add_digit(value_one, c, field_negative);
      else if (field_number == 1) value_two = add_digit(value_two, c, field_negative);
    endfunction

    function void note_byte(octet_t c);
      frame_result_t r;
      logic [47:0]   ref_word;
      logic [47:0]   ena_word;
      ref_word = 48'(KW_REF) << (8 * (TYPE_MAX - 5));
      ena_word = 48'(KW_ENA) << (8 * (TYPE_MAX - 5));
      case (phase)
        PH_TYPE: begin
          if (c == CH_COMMA) begin
            phase          = PH_PAYLOAD;
            payload_count  = 0;
            field_number   = 0;
            at_field_start = 1'b1;
            field_negative = 1'b0;
            value_one      = 0;
            value_two      = 0;
          end else if (type_count >= TYPE_MAX) begin
            phase      = PH_HUNT;
            type_count = 0;
          end else begin
            type_store |= 48'(c) << (8 * (TYPE_MAX - 1 - type_count));
            type_count++;
          end
        end
        PH_PAYLOAD: begin
          if (c == CH_STAR) begin
            phase          = PH_HUNT;
            r.type_chars   = type_store;
            r.type_length  = 3'(type_count);
            r.first_value  = 16'(value_one);
            r.second_value = 16'(value_two);
            r.is_reference = (TYPE_MAX >= 5 && type_count == 5 && type_store == ref_word);
            r.is_enable    = (TYPE_MAX >= 5 && type_count == 5 && type_store == ena_word);
            owed_frames.push_back(r);
          end else if (payload_count >= PAYLOAD_MAX) begin
            phase         = PH_HUNT;
            payload_count = 0;
          end else begin
            decode_payload_byte(c);
            payload_count++;
          end
        end
        default: begin
          phase = PH_HUNT;
          if (c == CH_DOLLAR) begin
            phase      = PH_TYPE;
            type_count = 0;
            type_store = '0;
          end
        end
      endcase
    endfunction

    function void check_frame(logic [OUT_TDATA_W-1:0] word);
      frame_result_t e;
      if (owed_frames.size() == 0) begin
        $error("result with no frame pending: tdata %h", word);
        errors++;
        return;
      end
      e = owed_frames.pop_front();
      frames_checked++;
      if (e.is_reference || e.is_enable) keyword_frames++;
      if (e.first_value == 16'sh7fff || e.first_value == 16'sh8000 ||
          e.second_value == 16'sh7fff || e.second_value == 16'sh8000) saturated_frames++;
      if (word[47:0] !== e.type_chars) begin
        $error("type_chars: expected %h, got %h", e.type_chars, word[47:0]);
        errors++;
      end
      if (word[50:48] !== e.type_length) begin
        $error("type_length: expected %0d, got %0d", e.type_length, word[50:48]);
        errors++;
      end
      if (word[66:51] !== e.first_value) begin
        $error("first_value: expected %0d, got %0d", e.first_value, $signed(word[66:51]));
        errors++;
      end
      if (word[82:67] !== e.second_value) begin
        $error("second_value: expected %0d, got %0d", e.second_value, $signed(word[82:67]));
        errors++;
      end
      if (word[83] !== e.is_reference) begin
        $error("is_reference: expected %0b, got %0b", e.is_reference, word[83]);
        errors++;
      end
      if (word[84] !== e.is_enable) begin
        $error("is_enable: expected %0b, got %0b", e.is_enable, word[84]);
        errors++;
      end
    endfunction

    function int frames_owed();
      return owed_frames.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  frame_scoreboard sb;
  octet_t          tx_bytes[$];
  int              tx_idle_pct;
  int              rx_idle_pct;
  int              bytes_sent;
  int              cycle_count;
  bit              hold_req;
  bit              offering;

  framed_message_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d frames pending", cycle_count,
               sb.frames_owed());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_frame(out_tdata);
  end

  // The receiver stalls at random, or for a long stretch when the sender asks for one.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic octet_t pick_byte(octet_t skip_a, octet_t skip_b);
    octet_t c;
    do c = octet_t'($urandom_range(255)); while (c == skip_a || c == skip_b);
    return c;
  endfunction

  // Appends one frame to the transmit queue: mostly well formed, some noise or broken.
  function automatic void queue_frame();
    octet_t      tq[$];
    octet_t      pq[$];
    int          kind;
    int          sel;
    int          tlen;
    int          nfields;
    int          ndigits;
    logic [39:0] kw;
    kind = $urandom_range(99);
    if ($urandom_range(3) == 0 || kind < 5) begin
      repeat ($urandom_range(1, 3)) tx_bytes.push_back(pick_byte(CH_DOLLAR, CH_DOLLAR));
    end
    if (kind < 5) return;
    tx_bytes.push_back(CH_DOLLAR);

    sel = $urandom_range(9);
    if (sel < 4 && kind >= 12) begin
      kw = (sel < 2) ? KW_REF : KW_ENA;
      for (int i = 0; i < 5; i++) tq.push_back(kw[39 - 8*i -: 8]);
      // Near misses: one character changed, or a sixth character added.
      if ($urandom_range(3) == 0) tq[$urandom_range(4)] = pick_byte(CH_COMMA, CH_COMMA);
      if ($urandom_range(4) == 0) tq.push_back(pick_byte(CH_COMMA, CH_COMMA));
    end else begin
      tlen = (kind < 12) ? $urandom_range(TYPE_MAX + 1, TYPE_MAX + 3)
                         : $urandom_range(0, TYPE_MAX);
      repeat (tlen) begin
        if ($urandom_range(1) == 0) tq.push_back(CH_UPPER_A + octet_t'($urandom_range(25)));
        else tq.push_back(pick_byte(CH_COMMA, CH_COMMA));
      end
    end
    foreach (tq[i]) tx_bytes.push_back(tq[i]);
    tx_bytes.push_back(CH_COMMA);

    nfields = $urandom_range(0, 4);
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) pq.push_back(CH_COMMA);
      sel = $urandom_range(9);
      if (sel < 3) pq.push_back(CH_MINUS);
      else if (sel < 5) pq.push_back(CH_PLUS);
      ndigits = $urandom_range(0, 6);
      repeat (ndigits) begin
        if ($urandom_range(11) == 0) pq.push_back(pick_byte(CH_STAR, CH_COMMA));
        else pq.push_back(CH_ZERO + octet_t'($urandom_range(9)));
      end
    end
    if (kind < 20) begin
      // Payload too long: the frame is dropped before its closing star.
      while (pq.size() < PAYLOAD_MAX + 1 + $urandom_range(2))
        pq.push_back(CH_ZERO + octet_t'($urandom_range(9)));
    end else begin
      while (pq.size() > PAYLOAD_MAX) void'(pq.pop_back());
    end
    foreach (pq[i]) tx_bytes.push_back(pq[i]);
    // A few frames are left open, so the next frame lands inside their payload.
    if (kind < 20 || kind >= 25) tx_bytes.push_back(CH_STAR);
  endfunction

  task automatic send_byte(input octet_t b);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    bytes_sent++;
    // Each idle cycle is drawn on its own, so the sender idles in about
    // tx_idle_pct cycles of a hundred.
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic wait_drain();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.frames_owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    string warmup;
    sb          = new();
    cycle_count = 0;
    bytes_sent  = 0;
    hold_req    = 1'b0;
    offering    = 1'b0;
    tx_idle_pct = 35;
    rx_idle_pct = 59;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Keyword type with saturation both ways, then an empty type and payload, then stray bytes.
    warmup = "$HLREF,99999,-99999*$,*";
    for (int i = 0; i < warmup.len(); i++) tx_bytes.push_back(warmup[i]);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());

    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent == RANDOM_BYTES / 3) begin
        wait_drain();
        tx_idle_pct = 59;
        rx_idle_pct = 35;
      end else if (bytes_sent == 2 * RANDOM_BYTES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
      end
      if (tx_bytes.size() == 0) queue_frame();
      send_byte(tx_bytes.pop_front());
    end
    wait_drain();

    $display("Sent %0d bytes; %0d frames checked, %0d with a keyword type, %0d saturated.",
             bytes_sent, sb.frames_checked, sb.keyword_frames, sb.saturated_frames);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
